/* hw/rtl/query_string_lexer_top_assert.svh */
// Assertion macros for the query string lexer checker.
`ifndef QUERY_STRING_LEXER_TOP_ASSERT_SVH
`define QUERY_STRING_LEXER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define QSL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("query string lexer check failed");

// Next-cycle implication, disabled in reset.
`define QSL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("query string lexer check failed");

`endif

/* hw/rtl/qsl_pkg.sv */
// Shared types, token codes and character classes of the query string lexer.
`default_nettype none
package qsl_pkg;

   // width of a word length or buffer index (covers every legal word bound)
   localparam int LEN_W = 6;

   // token kinds
   localparam logic [3:0] K_COLON    = 4'd0;
   localparam logic [3:0] K_LPAREN   = 4'd1;
   localparam logic [3:0] K_RPAREN   = 4'd2;
   localparam logic [3:0] K_LBRACKET = 4'd3;
   localparam logic [3:0] K_RBRACKET = 4'd4;
   localparam logic [3:0] K_LBRACE   = 4'd5;
   localparam logic [3:0] K_RBRACE   = 4'd6;
   localparam logic [3:0] K_MINUS    = 4'd7;
   localparam logic [3:0] K_WORD     = 4'd8;
   localparam logic [3:0] K_AND      = 4'd9;
   localparam logic [3:0] K_OR       = 4'd10;
   localparam logic [3:0] K_NOT      = 4'd11;
   localparam logic [3:0] K_TO       = 4'd12;
   localparam logic [3:0] K_STAR     = 4'd13;
   localparam logic [3:0] K_EOF      = 4'd14;

   // what a held '-' resolves to ahead of the rest of the command
   localparam logic [1:0] PRE_NONE  = 2'd0;
   localparam logic [1:0] PRE_MINUS = 2'd1;
   localparam logic [1:0] PRE_DASH  = 2'd2;

   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_STAR = 8'h2A;

   // one command from the classifier to the emitter, in emission order:
   // pre token, word flush (keyword or characters, then star), single token,
   // then a buffer write for the word being collected
   typedef struct packed {
      logic [1:0]       pre;
      logic             flush;
      logic             kw_hit;
      logic [3:0]       kw_kind;
      logic [LEN_W-1:0] wlen;
      logic             over;
      logic             star;
      logic             tok_en;
      logic [3:0]       tok_kind;
      logic             app_en;
      logic [7:0]       app_char;
      logic [LEN_W-1:0] app_idx;
   } cmd_type;

   // whitespace and NUL skipped at token start
   function automatic logic is_skip(input logic [7:0] c);
      return (c inside {8'h00, 8'h20, [8'h09:8'h0D]});
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c inside {8'h3A, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D});
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         8'h3A:   k = K_COLON;
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h5B:   k = K_LBRACKET;
         8'h5D:   k = K_RBRACKET;
         8'h7B:   k = K_LBRACE;
         8'h7D:   k = K_RBRACE;
         default: k = K_COLON;
      endcase
      return k;
   endfunction

   // VT, FF and CR continue a word; NUL, space, tab, newline and punctuation end it
   function automatic logic is_word_char(input logic [7:0] c);
      return !(c inside {8'h00, 8'h20, 8'h09, 8'h0A}) && !is_punct(c);
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/qsl_front.sv */
// Front end: takes query bytes, tracks word state and issues emitter commands.
`default_nettype none
module qsl_front #(
   parameter int MAX_WORD = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_ch,
   input  wire logic             req_end_mark,
   input  wire logic             req_push,
   output logic                  req_full,
   output qsl_pkg::cmd_type      cmd_data,
   output logic                  cmd_push,
   input  wire logic             cmd_full
);
   import qsl_pkg::*;

   logic             in_word_ff, in_word_in;
   logic             minus_ff, minus_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             over_ff, over_in;
   logic [7:0]       final_ff, final_in;
   logic [7:0]       k0_ff, k0_in, k1_ff, k1_in, k2_ff, k2_in;

   logic             accept;
   logic             start_tok;
   logic             kw_and, kw_or, kw_not, kw_to, kw_hit;
   logic [3:0]       kw_kind;
   logic             star_w;
   cmd_type          cmd;

   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;

   // match the held word against the keywords
   assign kw_and = (len_ff == LEN_W'(3)) && ({k0_ff, k1_ff, k2_ff} == "AND");
   assign kw_not = (len_ff == LEN_W'(3)) && ({k0_ff, k1_ff, k2_ff} == "NOT");
   assign kw_or  = (len_ff == LEN_W'(2)) && ({k0_ff, k1_ff} == "OR");
   assign kw_to  = (len_ff == LEN_W'(2)) && ({k0_ff, k1_ff} == "TO");
   assign kw_hit = !over_ff && (kw_and || kw_not || kw_or || kw_to);
   assign kw_kind = kw_and ? K_AND : kw_not ? K_NOT : kw_or ? K_OR : K_TO;
   assign star_w = !kw_hit && (final_ff == CH_STAR) && (over_ff || len_ff > LEN_W'(1));

   // classify the byte against the current word state
   always_comb begin
      in_word_in = in_word_ff;
      minus_in   = minus_ff;
      len_in     = len_ff;
      over_in    = over_ff;
      final_in   = final_ff;
      k0_in      = k0_ff;
      k1_in      = k1_ff;
      k2_in      = k2_ff;
      start_tok  = 1'b0;
      cmd        = '0;

      if (accept) begin
         if (req_end_mark) begin
            cmd.pre      = minus_ff ? PRE_DASH : PRE_NONE;
            cmd.flush    = in_word_ff;
            cmd.tok_en   = 1'b1;
            cmd.tok_kind = K_EOF;
            in_word_in   = 1'b0;
            minus_in     = 1'b0;
            len_in       = '0;
            over_in      = 1'b0;
            final_in     = '0;
         end else begin
            if (minus_ff) begin
               minus_in  = 1'b0;
               cmd.pre   = is_word_char(req_ch) ? PRE_MINUS : PRE_DASH;
               start_tok = 1'b1;
            end else if (in_word_ff) begin
               if (is_word_char(req_ch)) begin
                  // extend the word; past the bound only flag it
                  if (len_ff < LEN_W'(MAX_WORD)) begin
                     cmd.app_en   = 1'b1;
                     cmd.app_char = req_ch;
                     cmd.app_idx  = len_ff;
                     len_in       = len_ff + LEN_W'(1);
                     if (len_ff == LEN_W'(1)) k1_in = req_ch;
                     if (len_ff == LEN_W'(2)) k2_in = req_ch;
                  end else begin
                     over_in = 1'b1;
                  end
                  final_in = req_ch;
               end else begin
                  cmd.flush  = 1'b1;
                  in_word_in = 1'b0;
                  len_in     = '0;
                  over_in    = 1'b0;
                  final_in   = '0;
                  start_tok  = 1'b1;
               end
            end else begin
               start_tok = 1'b1;
            end

            // handle the byte at token start
            if (start_tok && !is_skip(req_ch)) begin
               if (is_punct(req_ch)) begin
                  cmd.tok_en   = 1'b1;
                  cmd.tok_kind = punct_kind(req_ch);
               end else if (req_ch == CH_DASH) begin
                  minus_in = 1'b1;
               end else begin
                  cmd.app_en   = 1'b1;
                  cmd.app_char = req_ch;
                  cmd.app_idx  = '0;
                  in_word_in   = 1'b1;
                  len_in       = LEN_W'(1);
                  over_in      = 1'b0;
                  final_in     = req_ch;
                  k0_in        = req_ch;
               end
            end
         end

         // attach what the flushed word needs
         cmd.kw_hit  = kw_hit;
         cmd.kw_kind = kw_kind;
         cmd.over    = over_ff;
         cmd.star    = cmd.flush && star_w;
         cmd.wlen    = (star_w && !over_ff) ? (len_ff - LEN_W'(1)) : len_ff;
      end
   end

   // drop commands that neither emit nor write
   assign cmd_data = cmd;
   assign cmd_push = accept &&
                     (cmd.pre != PRE_NONE || cmd.flush || cmd.tok_en || cmd.app_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         minus_ff   <= 1'b0;
         len_ff     <= '0;
         over_ff    <= 1'b0;
         final_ff   <= '0;
      end else begin
         in_word_ff <= in_word_in;
         minus_ff   <= minus_in;
         len_ff     <= len_in;
         over_ff    <= over_in;
         final_ff   <= final_in;
      end
   end

   // first characters of the word, for keyword matching
   always_ff @(posedge clock) begin
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      k2_ff <= k2_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/qsl_cmd_fifo.sv */
// Two-entry command queue between the front end and the emitter.
`default_nettype none
module qsl_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire qsl_pkg::cmd_type push_data,
   input  wire logic             push,
   output logic                  full,
   output qsl_pkg::cmd_type      pop_data,
   input  wire logic             pop,
   output logic                  empty
);
   import qsl_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (PW+1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

/* hw/rtl/qsl_back.sv */
// Emitter: runs commands, holds the word buffer and drives the result register.
`default_nettype none
module qsl_back #(
   parameter int MAX_WORD = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire qsl_pkg::cmd_type cmd_data,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output logic [3:0]            rsp_kind,
   output logic [7:0]            rsp_text_byte,
   output logic                  rsp_word_start,
   output logic                  rsp_word_end,
   output logic                  rsp_truncated,
   output logic                  rsp_last,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop
);
   import qsl_pkg::*;

   localparam int AW = $clog2(MAX_WORD);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRE  = 3'd1;
   localparam logic [2:0] ST_KW   = 3'd2;
   localparam logic [2:0] ST_WORD = 3'd3;
   localparam logic [2:0] ST_STAR = 3'd4;
   localparam logic [2:0] ST_TOK  = 3'd5;
   localparam logic [2:0] ST_APP  = 3'd6;

   logic [2:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    rdata_ff;
   logic [7:0]    word_mem [MAX_WORD];

   logic          out_valid_ff, out_valid_in;
   logic [3:0]    kind_ff, kind_in;
   logic [7:0]    text_ff, text_in;
   logic          ws_ff, ws_in, we_ff, we_in, tr_ff, tr_in, last_ff, last_in;

   logic          can_load, emit;
   logic [2:0]    next_st;
   logic          last_flag, word_last;

   // phase that follows ph for command c
   function automatic logic [2:0] after_phase(input cmd_type c, input logic [2:0] ph);
      logic [2:0] s_app, s_tok, s_star, s_flush, r;
      s_app   = c.app_en ? ST_APP : ST_IDLE;
      s_tok   = c.tok_en ? ST_TOK : s_app;
      s_star  = c.star   ? ST_STAR : s_tok;
      s_flush = c.flush  ? (c.kw_hit ? ST_KW : ST_WORD) : s_star;
      case (ph)
         ST_IDLE: r = (c.pre != PRE_NONE) ? ST_PRE : s_flush;
         ST_PRE:  r = s_flush;
         ST_KW:   r = s_star;
         ST_WORD: r = s_star;
         ST_STAR: r = s_tok;
         ST_TOK:  r = s_app;
         default: r = ST_IDLE;
      endcase
      return r;
   endfunction

   assign can_load  = !out_valid_ff || rsp_pop;
   assign next_st   = after_phase(cmd_ff, state_ff);
   assign last_flag = (next_st == ST_IDLE) || (next_st == ST_APP);
   assign word_last = (LEN_W'(idx_ff) + LEN_W'(1)) == cmd_ff.wlen;

   // step through the phases of the held command
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = '0;
      cmd_pop      = 1'b0;
      emit         = 1'b0;
      kind_in      = kind_ff;
      text_in      = '0;
      ws_in        = 1'b0;
      we_in        = 1'b0;
      tr_in        = 1'b0;
      last_in      = last_flag;

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               state_in = after_phase(cmd_data, ST_IDLE);
            end
         end
         ST_PRE: begin
            emit = can_load;
            if (cmd_ff.pre == PRE_DASH) begin
               kind_in = K_WORD;
               text_in = CH_DASH;
               ws_in   = 1'b1;
               we_in   = 1'b1;
            end else begin
               kind_in = K_MINUS;
            end
            if (can_load) state_in = next_st;
         end
         ST_KW: begin
            emit    = can_load;
            kind_in = cmd_ff.kw_kind;
            if (can_load) state_in = next_st;
         end
         ST_WORD: begin
            idx_in  = idx_ff;
            emit    = can_load;
            kind_in = K_WORD;
            text_in = rdata_ff;
            ws_in   = (idx_ff == '0);
            we_in   = word_last;
            tr_in   = word_last && cmd_ff.over;
            last_in = word_last && last_flag;
            if (can_load) begin
               if (word_last) begin
                  state_in = next_st;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         ST_STAR: begin
            emit    = can_load;
            kind_in = K_STAR;
            if (can_load) state_in = next_st;
         end
         ST_TOK: begin
            emit    = can_load;
            kind_in = cmd_ff.tok_kind;
            if (can_load) state_in = next_st;
         end
         ST_APP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the command and load the result register
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         kind_ff <= kind_in;
         text_ff <= text_in;
         ws_ff   <= ws_in;
         we_ff   <= we_in;
         tr_ff   <= tr_in;
         last_ff <= last_in;
      end
   end

   // word buffer: write the collected character, read ahead at the next index
   always_ff @(posedge clock) begin
      if (state_ff == ST_APP) word_mem[cmd_ff.app_idx[AW-1:0]] <= cmd_ff.app_char;
      rdata_ff <= word_mem[idx_in];
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_text_byte  = text_ff;
   assign rsp_word_start = ws_ff;
   assign rsp_word_end   = we_ff;
   assign rsp_truncated  = tr_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

/* hw/rtl/query_string_lexer_top.sv */
// Top level of the query string lexer: front end, command queue and emitter.
//
//   channel   direction  handshake         beat carries
//   req_      in         req_push/req_full ch, end_mark
//   rsp_      out        rsp_empty/rsp_pop kind, text_byte, word_start, word_end,
//                                          truncated, last
//
// The front end takes a byte whenever the command queue has room.
// The emitter fetches each command in its idle state, emits one result per cycle while
// rsp_pop keeps up, and writes a word character into the buffer in a state of its own.
// Reset is synchronous and clears control state; the word buffer is not cleared.
// A stalled result holds on the ports; the queue lets the front run ahead by two.
`default_nettype none
module query_string_lexer_top #(
   parameter int MAX_WORD = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_end_mark,
   input  wire logic        req_push,
   output logic             req_full,
   output logic [3:0]       rsp_kind,
   output logic [7:0]       rsp_text_byte,
   output logic             rsp_word_start,
   output logic             rsp_word_end,
   output logic             rsp_truncated,
   output logic             rsp_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop
);
   import qsl_pkg::*;

   cmd_type push_cmd, pop_cmd;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;

   qsl_front #(
      .MAX_WORD (MAX_WORD)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .req_end_mark (req_end_mark),
      .req_push     (req_push),
      .req_full     (req_full),
      .cmd_data     (push_cmd),
      .cmd_push     (cmd_push),
      .cmd_full     (cmd_full)
   );

   qsl_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_data (push_cmd),
      .push      (cmd_push),
      .full      (cmd_full),
      .pop_data  (pop_cmd),
      .pop       (cmd_pop),
      .empty     (cmd_empty)
   );

   qsl_back #(
      .MAX_WORD (MAX_WORD)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_data       (pop_cmd),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .rsp_kind       (rsp_kind),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_word_start (rsp_word_start),
      .rsp_word_end   (rsp_word_end),
      .rsp_truncated  (rsp_truncated),
      .rsp_last       (rsp_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule
`default_nettype wire

/* hw/rtl/qsl_checker.sv */
// Port-level checks on the query string lexer, bound to the top level.
`default_nettype none
`include "query_string_lexer_top_assert.svh"
module qsl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic [3:0] rsp_kind,
   input wire logic [7:0] rsp_text_byte,
   input wire logic       rsp_word_start,
   input wire logic       rsp_word_end,
   input wire logic       rsp_truncated,
   input wire logic       rsp_last,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop
);
   import qsl_pkg::*;

   logic        rsp_shown, rsp_is_word, rsp_plain;
   logic [15:0] rsp_beat;

   assign rsp_shown   = !rsp_empty;
   assign rsp_is_word = (rsp_kind == K_WORD);
   assign rsp_beat    = {rsp_kind, rsp_text_byte, rsp_word_start, rsp_word_end,
                         rsp_truncated, rsp_last};
   assign rsp_plain   = (rsp_text_byte == 8'h00) && !rsp_word_start && !rsp_word_end &&
                        !rsp_truncated;

   // a waiting result holds until taken
   `QSL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_shown && !rsp_pop, rsp_shown && $stable(rsp_beat))

   // only word characters carry text and word markers
   `QSL_ASSERT_IMP(a_word_fields, clock, reset, rsp_shown && !rsp_is_word, rsp_plain)

   // truncation is reported on the closing character only
   `QSL_ASSERT_IMP(a_trunc_end, clock, reset, rsp_shown && rsp_truncated, rsp_word_end)

   // end of query always closes the item's results
   `QSL_ASSERT_IMP(a_eof_last, clock, reset, rsp_shown && rsp_kind == K_EOF, rsp_last)

endmodule

bind query_string_lexer_top qsl_checker u_qsl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_kind       (rsp_kind),
   .rsp_text_byte  (rsp_text_byte),
   .rsp_word_start (rsp_word_start),
   .rsp_word_end   (rsp_word_end),
   .rsp_truncated  (rsp_truncated),
   .rsp_last       (rsp_last),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop)
);
`default_nettype wire
